// ===== hdl/sha256_pkg.sv =====
// SHA-256 constants and round functions shared by the hasher core.
// No dependencies.
package sha256_pkg;

   localparam int unsigned BlockBytes = 64;

   typedef logic [31:0] word_type;

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type InitH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PadByte = 8'h80;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type sig0(input word_type x);
      sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sig1(input word_type x);
      sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type bsig0(input word_type x);
      bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type bsig1(input word_type x);
      bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

// ===== hdl/sha256_stream_hasher_core.sv =====
// SHA-256 stream hasher: byte collection into a block memory, padding and
// 64-round compression, one round per cycle. Uses sha256_pkg.
// A byte is accepted while idle; the 64th byte of a block starts a compression:
//   load of the block into the schedule window, the rounds, then the chain update.
// End of message: padding up to the end of the block and a compression, again padding
//   and a compression when a second block is needed, then 8 digest transfers.
// Reset: synchronous, active high; chain words to initial values, counts zero.
module sha256_stream_hasher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_valid
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
   output logic        rsp_tlast    // last_word
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_UPDATE, ST_OUT
   } state_type;

   state_type               state_ff;
   logic [5:0]              fill_ff;
   logic [63:0]             bits_ff;
   logic [63:0]             total_ff;
   logic                    eom_ff;     // message end seen: update goes on to padding or digest output
   logic                    second_ff;  // padding needs a second block
   logic                    mark_ff;    // 0x80 still to be placed at fill position
   logic [6:0]              cnt_ff;
   logic [2:0]              widx_ff;
   sha256_pkg::word_type    h_ff [8];
   sha256_pkg::word_type    v_ff [8];
   sha256_pkg::word_type    w_ff [16];  // message schedule window

   // block buffer memory, byte wide, registered read
   logic [7:0]              mem [64];
   logic [7:0]              rd_ff;
   logic                    mem_we;
   logic [5:0]              mem_wa;
   logic [7:0]              mem_wd;
   logic [5:0]              mem_ra;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[mem_ra];
   end

   logic req_xfer;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer = req_tvalid && req_tready;

   // padding byte for position cnt
   logic [7:0] pad_byte;
   logic [2:0] len_sel;
   assign len_sel = cnt_ff[2:0];
   always_comb begin
      pad_byte = 8'h00;
      if (!second_ff && cnt_ff[5:0] >= 6'd56)
         pad_byte = total_ff[6'd63 - {len_sel, 3'b000} -: 8];
      if (cnt_ff[5:0] == fill_ff && mark_ff) pad_byte = sha256_pkg::PadByte;
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = fill_ff;
      mem_wd = req_tdata;
      mem_ra = cnt_ff[5:0];
      if (req_xfer && req_tuser) mem_we = 1'b1;
      if (state_ff == ST_PAD) begin
         mem_we = 1'b1;
         mem_wa = cnt_ff[5:0];
         mem_wd = pad_byte;
      end
   end

   // round datapath
   sha256_pkg::word_type w_cur, t1, t2, w_new, ch, maj;
   always_comb begin
      w_cur = w_ff[0];
      w_new = sha256_pkg::sig1(w_ff[14]) + w_ff[9] + sha256_pkg::sig0(w_ff[1]) + w_ff[0];
      ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1 = v_ff[7] + sha256_pkg::bsig1(v_ff[4]) + ch + sha256_pkg::RoundK[cnt_ff[5:0]] + w_cur;
      t2 = sha256_pkg::bsig0(v_ff[0]) + maj;
   end

   logic [5:0] fill_p1;
   logic [5:0] pad_start;
   logic [5:0] ld_addr;
   assign fill_p1 = fill_ff + 6'd1;
   assign pad_start = req_tuser ? fill_p1 : fill_ff;
   assign ld_addr = cnt_ff[5:0] - 6'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         bits_ff   <= '0;
         eom_ff    <= 1'b0;
         second_ff <= 1'b0;
         mark_ff   <= 1'b0;
         cnt_ff    <= '0;
         widx_ff   <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= sha256_pkg::InitH[i];
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  eom_ff <= req_tlast;
                  if (req_tuser && fill_ff == 6'd63) begin
                     fill_ff   <= fill_p1;
                     bits_ff   <= bits_ff + 64'd512;
                     // message ends on a block boundary: padding fills a fresh block
                     total_ff  <= bits_ff + 64'd512;
                     second_ff <= req_tlast;
                     mark_ff   <= req_tlast;
                     cnt_ff    <= '0;
                     state_ff  <= ST_LOAD;
                  end else if (req_tlast) begin
                     if (req_tuser) fill_ff <= fill_p1;
                     total_ff  <= bits_ff + {55'd0, pad_start, 3'b000};
                     second_ff <= (pad_start >= 6'd56);
                     mark_ff   <= 1'b1;
                     cnt_ff    <= {1'b0, pad_start};
                     state_ff  <= ST_PAD;
                  end else if (req_tuser) begin
                     fill_ff <= fill_p1;
                  end
               end
            end
            ST_PAD: begin
               if (cnt_ff[5:0] == 6'd63) begin
                  cnt_ff   <= '0;
                  eom_ff   <= 1'b1;
                  mark_ff  <= 1'b0;
                  if (second_ff) fill_ff <= '0;
                  state_ff <= ST_LOAD;
               end else begin
                  cnt_ff <= cnt_ff + 7'd1;
               end
            end
            ST_LOAD: begin
               // cnt runs 0..64; data for address cnt-1 arrives now
               if (cnt_ff != 7'd0)
                  w_ff[ld_addr[5:2]] <= {w_ff[ld_addr[5:2]][23:0], rd_ff};
               if (cnt_ff == 7'd64) begin
                  cnt_ff <= '0;
                  for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
                  state_ff <= ST_ROUND;
               end else begin
                  cnt_ff <= cnt_ff + 7'd1;
               end
            end
            ST_ROUND: begin
               v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
               w_ff[15] <= w_new;
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd63) state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               cnt_ff <= '0;
               if (!eom_ff) state_ff <= ST_IDLE;
               else if (second_ff) begin
                  second_ff <= 1'b0;
                  fill_ff   <= '0;
                  eom_ff    <= 1'b0;   // reused: second pass writes the 0x80 mark if still owed, zeros, then length
                  state_ff  <= ST_PAD;
               end else begin
                  widx_ff  <= '0;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_tready) begin
                  widx_ff <= widx_ff + 3'd1;
                  if (widx_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) h_ff[i] <= sha256_pkg::InitH[i];
                     fill_ff  <= '0;
                     bits_ff  <= '0;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {5'd0, widx_ff, h_ff[widx_ff]};
   assign rsp_tlast  = (widx_ff == 3'd7);

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("input open during digest output");
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("no return to idle after last word");
   a_round_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && cnt_ff == 7'd63) |=> state_ff == ST_UPDATE)
      else $error("round count slip");

endmodule
